FILE: hdl/far_pkg.sv
// ----------------------------------------------------------------------------
// far_pkg
// Shared types and constants for the fraction arithmetic reduce block.
// ----------------------------------------------------------------------------
package far_pkg;

   localparam int OperandWidth = 16;
   localparam int MagWidth     = 2 * OperandWidth + 1;
   localparam int NumWidth     = 33;
   localparam int DenWidth     = 31;
   localparam int RemWidth     = 30;
   localparam int CountWidth   = $clog2(MagWidth + 1);

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_DIV_ZERO = 2'd2;

   // Datapath commands from the controller
   typedef struct packed {
      logic load;
      logic form;
      logic gcd_start;
      logic div_num_start;
      logic div_den_start;
      logic div_whole_start;
      logic div_step;
      logic finish;
   } cmd_type;

   // Status back to the controller
   typedef struct packed {
      logic err;
      logic gcd_done;
      logic div_done;
   } stat_type;

endpackage

FILE: hdl/far_datapath.sv
// ----------------------------------------------------------------------------
// far_datapath
// Cross multiplication, Euclid by restoring division, reduction and whole part.
// ----------------------------------------------------------------------------
module far_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [1:0]                      req_opcode,
   input  logic [far_pkg::OperandWidth-1:0] req_left_num,
   input  logic [far_pkg::OperandWidth-1:0] req_left_den,
   input  logic [far_pkg::OperandWidth-1:0] req_right_num,
   input  logic [far_pkg::OperandWidth-1:0] req_right_den,
   input  far_pkg::cmd_type                cmd,
   output far_pkg::stat_type               stat,
   output logic [far_pkg::NumWidth-1:0]    rsp_result_num,
   output logic [far_pkg::DenWidth-1:0]    rsp_result_den,
   output logic [far_pkg::NumWidth-1:0]    rsp_whole_part,
   output logic [far_pkg::RemWidth-1:0]    rsp_remainder_mag,
   output logic [1:0]                      rsp_status
);
   import far_pkg::*;

   localparam int W  = OperandWidth;
   localparam int PW = 2 * W;

   // operand registers (sign-magnitude)
   logic [1:0]   op_ff;
   logic [W:0]   ln_ff, ld_ff, rn_ff, rd_ff;
   logic         lns_ff, lds_ff, rns_ff, rds_ff;
   // products
   logic [PW-1:0] p0_ff, p1_ff;
   logic          p0s_ff, p1s_ff;
   logic          phase_ff;
   // working values
   logic [MagWidth-1:0] num_ff, den_ff, a_ff, b_ff;
   logic                nneg_ff, dneg_ff;
   logic                err_ff;
   logic [1:0]          status_ff;
   // divider
   logic [MagWidth-1:0] dq_ff, dr_ff, dd_ff;
   logic [CountWidth-1:0] dcnt_ff;
   logic                dbusy_ff, ddone_ff;
   logic [1:0]          dmode_ff;
   logic [MagWidth-1:0] quo_ff;

   localparam logic [1:0] DM_GCD = 2'd0, DM_NUM = 2'd1, DM_DEN = 2'd2, DM_WHOLE = 2'd3;

   function automatic logic [W:0] mag_of(input logic [W-1:0] v);
      return v[W-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
   endfunction

   logic [MagWidth:0]   trial;
   logic [MagWidth-1:0] rsh;
   logic [W:0]          ma, mb;
   logic                sa, sb;
   logic [PW-1:0]       prod;
   logic [MagWidth-1:0] e0, e1;
   logic                neg;

   assign rsh   = {dr_ff[MagWidth-2:0], dq_ff[MagWidth-1]};
   assign trial = {1'b0, rsh} - {1'b0, dd_ff};
   assign neg   = (num_ff != '0) && (nneg_ff != dneg_ff);
   assign e0    = {{(MagWidth-PW){1'b0}}, p0_ff};
   assign e1    = {{(MagWidth-PW){1'b0}}, p1_ff};

   // select multiplier operands by phase
   always_comb begin
      if (!phase_ff) begin
         ma = ln_ff; sa = lns_ff;
         mb = (op_ff == OP_MUL) ? rn_ff : rd_ff;
         sb = (op_ff == OP_MUL) ? rns_ff : rds_ff;
      end else begin
         ma = ld_ff; sa = lds_ff;
         mb = (op_ff == OP_DIV) ? rn_ff : rd_ff;
         sb = (op_ff == OP_DIV) ? rns_ff : rds_ff;
         if (op_ff == OP_ADD || op_ff == OP_SUB) begin
            ma = rn_ff; sa = rns_ff ^ (op_ff == OP_SUB);
            mb = ld_ff; sb = lds_ff;
         end
      end
      prod = PW'(ma[W-1:0] * mb[W-1:0]) + (ma[W] ? PW'(mb[W-1:0]) << W : '0)
           + (mb[W] ? PW'(ma) << W : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         ddone_ff <= 1'b0;
         phase_ff <= 1'b0;
         err_ff   <= 1'b0;
      end else begin
         ddone_ff <= 1'b0;
         // capture operands and check errors
         if (cmd.load) begin
            op_ff  <= req_opcode;
            ln_ff  <= mag_of(req_left_num);  lns_ff <= req_left_num[W-1];
            ld_ff  <= mag_of(req_left_den);  lds_ff <= req_left_den[W-1];
            rn_ff  <= mag_of(req_right_num); rns_ff <= req_right_num[W-1];
            rd_ff  <= mag_of(req_right_den); rds_ff <= req_right_den[W-1];
            phase_ff <= 1'b0;
            if (req_left_den == '0 || req_right_den == '0) begin
               err_ff <= 1'b1; status_ff <= ST_ZERO_DEN;
            end else if (req_opcode == OP_DIV && req_right_num == '0) begin
               err_ff <= 1'b1; status_ff <= ST_DIV_ZERO;
            end else begin
               err_ff <= 1'b0; status_ff <= ST_OK;
            end
         end
         // two multiplier passes, then combine
         if (cmd.form) begin
            if (!phase_ff) begin
               p0_ff <= prod; p0s_ff <= (prod != '0) && (sa ^ sb);
               phase_ff <= 1'b1;
            end else begin
               p1_ff <= prod; p1s_ff <= (prod != '0) && (sa ^ sb);
               phase_ff <= 1'b0;
            end
         end
         if (cmd.gcd_start) begin
            // combine products into num/den
            if (op_ff == OP_ADD || op_ff == OP_SUB) begin
               den_ff  <= {{(MagWidth-W-W){1'b0}}, PW'(ld_ff * rd_ff)};
               dneg_ff <= lds_ff ^ rds_ff;
               if (p0s_ff == p1s_ff) begin
                  num_ff <= e0 + e1; nneg_ff <= p0s_ff;
               end else if (p0_ff >= p1_ff) begin
                  num_ff <= e0 - e1; nneg_ff <= p0s_ff;
               end else begin
                  num_ff <= e1 - e0; nneg_ff <= p1s_ff;
               end
               a_ff <= '0; b_ff <= '0;
            end else begin
               num_ff <= e0; nneg_ff <= p0s_ff;
               den_ff <= e1; dneg_ff <= p1s_ff;
            end
            dbusy_ff <= 1'b0;
         end
         // start a divide: num/g, den/g, num/den
         if (cmd.div_num_start || cmd.div_den_start || cmd.div_whole_start) begin
            dbusy_ff <= 1'b1;
            dcnt_ff  <= CountWidth'(MagWidth);
            dr_ff    <= '0;
            if (cmd.div_num_start) begin
               dq_ff <= num_ff; dd_ff <= a_ff; dmode_ff <= DM_NUM;
            end else if (cmd.div_den_start) begin
               dq_ff <= den_ff; dd_ff <= a_ff; dmode_ff <= DM_DEN;
            end else begin
               dq_ff <= num_ff; dd_ff <= den_ff; dmode_ff <= DM_WHOLE;
            end
         end
         // Euclid: a = num, b = den; iterate a mod b
         if (cmd.div_step) begin
            if (dmode_ff == DM_GCD && !dbusy_ff) begin
               if (b_ff == '0) begin
                  ddone_ff <= 1'b1;
               end else begin
                  dbusy_ff <= 1'b1; dcnt_ff <= CountWidth'(MagWidth);
                  dr_ff <= '0; dq_ff <= a_ff; dd_ff <= b_ff;
               end
            end else if (dbusy_ff) begin
               dcnt_ff <= dcnt_ff - 1'b1;
               if (!trial[MagWidth]) begin
                  dr_ff <= trial[MagWidth-1:0];
                  dq_ff <= {dq_ff[MagWidth-2:0], 1'b1};
               end else begin
                  dr_ff <= rsh;
                  dq_ff <= {dq_ff[MagWidth-2:0], 1'b0};
               end
               if (dcnt_ff == CountWidth'(1)) begin
                  dbusy_ff <= 1'b0;
                  if (dmode_ff == DM_GCD) begin
                     a_ff <= b_ff;
                     b_ff <= trial[MagWidth] ? rsh : trial[MagWidth-1:0];
                  end else begin
                     ddone_ff <= 1'b1;
                     quo_ff <= {dq_ff[MagWidth-2:0], ~trial[MagWidth]};
                     if (dmode_ff == DM_NUM) num_ff <= {dq_ff[MagWidth-2:0], ~trial[MagWidth]};
                     if (dmode_ff == DM_DEN) den_ff <= {dq_ff[MagWidth-2:0], ~trial[MagWidth]};
                  end
               end
            end
         end
         // seed Euclid in the cycle after forming num/den
         if (cmd.finish) begin
            a_ff <= num_ff; b_ff <= den_ff; dmode_ff <= DM_GCD;
         end
      end
   end

   assign stat.err      = err_ff;
   assign stat.gcd_done = ddone_ff && dmode_ff == DM_GCD;
   assign stat.div_done = ddone_ff && dmode_ff != DM_GCD;

   // result fields, zeroed on error (denominator one)
   always_comb begin
      rsp_status = status_ff;
      if (err_ff) begin
         rsp_result_num = '0; rsp_result_den = DenWidth'(1);
         rsp_whole_part = '0; rsp_remainder_mag = '0;
      end else begin
         rsp_result_num = neg ? NumWidth'(-num_ff) : NumWidth'(num_ff);
         rsp_result_den = den_ff[DenWidth-1:0];
         rsp_whole_part = (neg && quo_ff != '0) ? NumWidth'(-quo_ff) : NumWidth'(quo_ff);
         rsp_remainder_mag = dr_ff[RemWidth-1:0];
      end
   end

endmodule

FILE: hdl/far_ctrl.sv
// ----------------------------------------------------------------------------
// far_ctrl
// Sequencer for load, multiply, gcd, reduce and whole-part division.
// ----------------------------------------------------------------------------
module far_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   output far_pkg::cmd_type  cmd,
   input  far_pkg::stat_type stat
);
   import far_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_CHECK = 4'd1, S_MUL0 = 4'd2, S_MUL1 = 4'd3,
                          S_FORM = 4'd4, S_SEED = 4'd5, S_GCD = 4'd6, S_DNUM = 4'd7,
                          S_WNUM = 4'd8, S_DDEN = 4'd9, S_WDEN = 4'd10, S_DWH = 4'd11,
                          S_WWH = 4'd12, S_OUT = 4'd13;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (start) begin cmd.load = 1'b1; state_in = S_CHECK; end
         S_CHECK: state_in = stat.err ? S_OUT : S_MUL0;
         S_MUL0:  begin cmd.form = 1'b1; state_in = S_MUL1; end
         S_MUL1:  begin cmd.form = 1'b1; state_in = S_FORM; end
         S_FORM:  begin cmd.gcd_start = 1'b1; state_in = S_SEED; end
         S_SEED:  begin cmd.finish = 1'b1; state_in = S_GCD; end
         S_GCD:   begin cmd.div_step = 1'b1; if (stat.gcd_done) state_in = S_DNUM; end
         S_DNUM:  begin cmd.div_num_start = 1'b1; state_in = S_WNUM; end
         S_WNUM:  begin cmd.div_step = 1'b1; if (stat.div_done) state_in = S_DDEN; end
         S_DDEN:  begin cmd.div_den_start = 1'b1; state_in = S_WDEN; end
         S_WDEN:  begin cmd.div_step = 1'b1; if (stat.div_done) state_in = S_DWH; end
         S_DWH:   begin cmd.div_whole_start = 1'b1; state_in = S_WWH; end
         S_WWH:   begin cmd.div_step = 1'b1; if (stat.div_done) state_in = S_OUT; end
         S_OUT:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_OUT;

endmodule

FILE: hdl/fraction_arithmetic_reduce.sv
// ----------------------------------------------------------------------------
// fraction_arithmetic_reduce
// Fraction add/sub/mul/div with gcd reduction and mixed-form whole part.
// ----------------------------------------------------------------------------
// One item at a time; busy holds through the result beat, and the next item
// is taken in the cycle after it at the earliest.
// The restoring divider (one quotient bit a cycle) sets the latency.
// Errors go from accept through the check state to the result beat. Synchronous reset to idle.
// The result beat is shown for one cycle; the receiver cannot stall.
module fraction_arithmetic_reduce (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_opcode,
   input  logic [far_pkg::OperandWidth-1:0] req_left_num,
   input  logic [far_pkg::OperandWidth-1:0] req_left_den,
   input  logic [far_pkg::OperandWidth-1:0] req_right_num,
   input  logic [far_pkg::OperandWidth-1:0] req_right_den,
   output logic                            rsp_valid,
   output logic [far_pkg::NumWidth-1:0]    rsp_result_num,
   output logic [far_pkg::DenWidth-1:0]    rsp_result_den,
   output logic [far_pkg::NumWidth-1:0]    rsp_whole_part,
   output logic [far_pkg::RemWidth-1:0]    rsp_remainder_mag,
   output logic [1:0]                      rsp_status
);
   import far_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   far_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .rsp_valid, .cmd, .stat
   );

   far_datapath u_dp (
      .clock, .reset, .req_opcode, .req_left_num, .req_left_den, .req_right_num,
      .req_right_den, .cmd, .stat, .rsp_result_num, .rsp_result_den,
      .rsp_whole_part, .rsp_remainder_mag, .rsp_status
   );

endmodule

FILE: hdl/far_checker.sv
// ----------------------------------------------------------------------------
// far_checker
// Port-level checks on the command handshake and result beats.
// ----------------------------------------------------------------------------
module far_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic [far_pkg::DenWidth-1:0] rsp_result_den,
   input logic [1:0]                   rsp_status
);
   import far_pkg::*;

   // accept leads to busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");
   // a beat ends the item
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after beat");
   // beat only while busy
   a_vb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("beat while idle");
   // denominator never zero
   a_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_den != '0) else $error("zero denominator");
   // status code in range
   a_st: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_ZERO_DEN ||
                     rsp_status == ST_DIV_ZERO)) else $error("bad status");

endmodule

bind fraction_arithmetic_reduce far_checker u_far_checker (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_result_den, .rsp_status
);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for fraction_arithmetic_reduce: a directed table of
// corner items, then random bursts, checked against typed answers or an exact predictor.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import far_pkg::*;

   localparam int W         = OperandWidth;
   localparam int MaxCycles = 10000000;

   typedef struct {
      logic [1:0]          opcode;
      logic [W-1:0]        left_num;
      logic [W-1:0]        left_den;
      logic [W-1:0]        right_num;
      logic [W-1:0]        right_den;
   } fraction_pair_type;

   typedef struct {
      logic [NumWidth-1:0] result_num;
      logic [DenWidth-1:0] result_den;
      logic [NumWidth-1:0] whole_part;
      logic [RemWidth-1:0] remainder_mag;
      logic [1:0]          status;
   } reduced_type;

   typedef struct {
      fraction_pair_type   pair;
      bit                  typed;
      reduced_type         answer;
   } table_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_opcode;
   logic [W-1:0]        req_left_num;
   logic [W-1:0]        req_left_den;
   logic [W-1:0]        req_right_num;
   logic [W-1:0]        req_right_den;
   logic                rsp_valid;
   logic [NumWidth-1:0] rsp_result_num;
   logic [DenWidth-1:0] rsp_result_den;
   logic [NumWidth-1:0] rsp_whole_part;
   logic [RemWidth-1:0] rsp_remainder_mag;
   logic [1:0]          rsp_status;

   reduced_type pending_fractions[$];
   int          mismatch_count;
   int          cycle_count;

   fraction_arithmetic_reduce dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_left_num      (req_left_num),
      .req_left_den      (req_left_den),
      .req_right_num     (req_right_num),
      .req_right_den     (req_right_den),
      .rsp_valid         (rsp_valid),
      .rsp_result_num    (rsp_result_num),
      .rsp_result_den    (rsp_result_den),
      .rsp_whole_part    (rsp_whole_part),
      .rsp_remainder_mag (rsp_remainder_mag),
      .rsp_status        (rsp_status)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Take the magnitude of a two's complement operand
   function automatic logic [63:0] operand_mag(input logic [W-1:0] v);
      return v[W-1] ? 64'((1 << W) - 64'(v)) : 64'(v);
   endfunction

   function automatic void signed_product(input logic sa, input logic [63:0] ma,
                                          input logic sb, input logic [63:0] mb,
                                          output logic s, output logic [63:0] m);
      m = ma * mb;
      s = (m != 0) && (sa != sb);
   endfunction

   function automatic void signed_sum(input logic sa, input logic [63:0] ma,
                                      input logic sb, input logic [63:0] mb,
                                      output logic s, output logic [63:0] m);
      if (sa == sb) begin
         m = ma + mb;
         s = sa;
      end else if (ma >= mb) begin
         m = ma - mb;
         s = sa;
      end else begin
         m = mb - ma;
         s = sb;
      end
      if (m == 0) s = 1'b0;
   endfunction

   // Work out the reduced fraction and mixed form for one pair
   function automatic reduced_type reduce_fraction(input fraction_pair_type p);
      reduced_type r;
      logic [63:0] lnm, ldm, rnm, rdm, nm, dm, am, bm, g, t, q, rem;
      logic        lns, lds, rns, rds, ns, ds, as_, bs, neg;
      lns = p.left_num[W-1];  lnm = operand_mag(p.left_num);
      lds = p.left_den[W-1];  ldm = operand_mag(p.left_den);
      rns = p.right_num[W-1]; rnm = operand_mag(p.right_num);
      rds = p.right_den[W-1]; rdm = operand_mag(p.right_den);
      r = '{result_num: '0, result_den: 1, whole_part: '0, remainder_mag: '0,
            status: ST_OK};
      if (ldm == 0 || rdm == 0) begin
         r.status = ST_ZERO_DEN;
         return r;
      end
      if (p.opcode == OP_DIV && rnm == 0) begin
         r.status = ST_DIV_ZERO;
         return r;
      end
      case (p.opcode) inside
         OP_ADD, OP_SUB: begin
            if (p.opcode == OP_SUB) rns = !rns;
            signed_product(lns, lnm, rds, rdm, as_, am);
            signed_product(rns, rnm, lds, ldm, bs, bm);
            signed_sum(as_, am, bs, bm, ns, nm);
            signed_product(lds, ldm, rds, rdm, ds, dm);
         end
         OP_MUL: begin
            signed_product(lns, lnm, rns, rnm, ns, nm);
            signed_product(lds, ldm, rds, rdm, ds, dm);
         end
         default: begin
            signed_product(lns, lnm, rds, rdm, ns, nm);
            signed_product(lds, ldm, rns, rnm, ds, dm);
         end
      endcase
      am = nm;
      bm = dm;
      while (bm != 0) begin
         t = am % bm;
         am = bm;
         bm = t;
      end
      g = am;
      nm = nm / g;
      dm = dm / g;
      neg = (nm != 0) && (ns != ds);
      q = nm / dm;
      rem = nm % dm;
      r.result_num = NumWidth'(neg ? -nm : nm);
      r.result_den = DenWidth'(dm);
      r.whole_part = NumWidth'((neg && q != 0) ? -q : q);
      r.remainder_mag = RemWidth'(rem);
      return r;
   endfunction

   function automatic logic [W-1:0] random_operand();
      case ($urandom_range(0, 9))
         0:       return {1'b1, {(W-1){1'b0}}};
         1:       return {1'b0, {(W-1){1'b1}}};
         2:       return '0;
         3, 4:    return W'($urandom_range(0, 8)) - W'(4);
         default: return W'($urandom);
      endcase
   endfunction

   // Drive one beat and hold it until the block is idle again
   task automatic send_pair(input fraction_pair_type p, input bit typed,
                            input reduced_type answer);
      req_opcode    <= p.opcode;
      req_left_num  <= p.left_num;
      req_left_den  <= p.left_den;
      req_right_num <= p.right_num;
      req_right_den <= p.right_den;
      start         <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_fractions.push_back(typed ? answer : reduce_fraction(p));
   endtask

   // Check each result beat against the oldest expectation
   always @(posedge clock) begin
      reduced_type e;
      if (!reset && rsp_valid) begin
         if (pending_fractions.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result beat");
         end else begin
            e = pending_fractions.pop_front();
            if (rsp_result_num !== e.result_num || rsp_result_den !== e.result_den ||
                rsp_whole_part !== e.whole_part ||
                rsp_remainder_mag !== e.remainder_mag || rsp_status !== e.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp %h/%h %h r%h s%0d got %h/%h %h r%h s%0d",
                           e.result_num, e.result_den, e.whole_part, e.remainder_mag,
                           e.status, rsp_result_num, rsp_result_den, rsp_whole_part,
                           rsp_remainder_mag, rsp_status);
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MaxCycles) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   localparam logic [W-1:0] MinV = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MaxV = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] One  = W'(1);
   localparam logic [W-1:0] NegOne = '1;

   initial begin
      table_row_type     stimulus_table[$];
      fraction_pair_type p;
      reduced_type       none;
      int                burst;
      none = '{result_num: '0, result_den: 1, whole_part: '0, remainder_mag: '0,
               status: ST_OK};
      mismatch_count = 0;
      cycle_count    = 0;
      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = OP_ADD;
      req_left_num   = '0;
      req_left_den   = One;
      req_right_num  = '0;
      req_right_den  = One;

      // Directed rows: error codes and obvious results typed in, the rest predicted
      stimulus_table = '{
         '{'{OP_ADD, One, '0, One, One}, 1, '{'0, 1, '0, '0, ST_ZERO_DEN}},
         '{'{OP_MUL, One, One, One, '0}, 1, '{'0, 1, '0, '0, ST_ZERO_DEN}},
         '{'{OP_DIV, One, One, '0, '0}, 1, '{'0, 1, '0, '0, ST_ZERO_DEN}},
         '{'{OP_DIV, MaxV, MinV, '0, One}, 1, '{'0, 1, '0, '0, ST_DIV_ZERO}},
         '{'{OP_SUB, One, One, One, One}, 1, '{'0, 1, '0, '0, ST_OK}},
         '{'{OP_MUL, '0, NegOne, MaxV, MinV}, 1, '{'0, 1, '0, '0, ST_OK}},
         '{'{OP_ADD, One, One, One, One}, 1, '{33'd2, 1, 33'd2, '0, ST_OK}},
         '{'{OP_ADD, MaxV, One, MaxV, One}, 0, none},
         '{'{OP_ADD, MinV, One, MinV, One}, 0, none},
         '{'{OP_SUB, MinV, One, MaxV, One}, 0, none},
         '{'{OP_SUB, MaxV, MinV, MinV, MaxV}, 0, none},
         '{'{OP_MUL, MinV, One, MinV, One}, 0, none},
         '{'{OP_MUL, MinV, MaxV, MaxV, MinV}, 0, none},
         '{'{OP_DIV, MinV, One, One, MaxV}, 0, none},
         '{'{OP_DIV, One, MinV, MaxV, One}, 0, none},
         '{'{OP_DIV, NegOne, NegOne, NegOne, NegOne}, 0, none},
         '{'{OP_ADD, One, W'(3), NegOne, W'(6)}, 0, none},
         '{'{OP_SUB, W'(7), NegOne, W'(2), W'(-3)}, 0, none},
         '{'{OP_MUL, W'(-9), W'(4), W'(2), W'(3)}, 0, none},
         '{'{OP_DIV, W'(5), W'(7), W'(-10), W'(21)}, 0, none},
         '{'{OP_ADD, MaxV, MaxV, MinV, MinV}, 0, none}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stimulus_table[i])
         send_pair(stimulus_table[i].pair, stimulus_table[i].typed,
                   stimulus_table[i].answer);

      // Random bursts with gaps; drain fully at least once mid-run
      for (int n = 0; n < 900; n += burst) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst; k++) begin
            p.opcode    = 2'($urandom);
            p.left_num  = random_operand();
            p.left_den  = random_operand();
            p.right_num = random_operand();
            p.right_den = random_operand();
            if ($urandom_range(0, 15) != 0) begin
               if (p.left_den == 0) p.left_den = W'($urandom_range(1, 1000));
               if (p.right_den == 0) p.right_den = NegOne;
            end
            send_pair(p, 0, none);
         end
         if (n >= 400 && n < 415) begin
            start <= 1'b0;
            while (pending_fractions.size() != 0) @(posedge clock);
         end else if ($urandom_range(0, 2) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 300)) @(posedge clock);
         end
      end

      start <= 1'b0;
      while (pending_fractions.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: fraction_arithmetic_reduce.f
hdl/far_pkg.sv
hdl/far_datapath.sv
hdl/far_ctrl.sv
hdl/fraction_arithmetic_reduce.sv
hdl/far_checker.sv
tb/tb_top.sv
